// ----- src/dpt_pkg.sv -----
// ----------------------------------------------------------------------------
// dpt_pkg
// shared types and constants for the delivery predictability table
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int DPT_NODE_COUNT = 256;
  localparam int DPT_FRAC_BITS  = 16;
  localparam int ID_W           = 8;
  localparam int FIELD_W        = DPT_FRAC_BITS + 1;
  localparam int TIME_W         = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  localparam logic [1:0] ACT_ENCOUNTER  = 2'd0;
  localparam logic [1:0] ACT_TRANSITIVE = 2'd1;
  localparam logic [1:0] ACT_READ       = 2'd2;
  localparam logic [1:0] ACT_NONE       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SELF_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P_INIT  = 2'd3;

  localparam logic [FIELD_W-1:0] GAMMA_RESET  = 17'd64225;
  localparam logic [FIELD_W-1:0] BETA_RESET   = 17'd16384;
  localparam logic [FIELD_W-1:0] P_INIT_RESET = 17'd49152;

  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_READ  = 10'b0000000100,
    ST_DIV   = 10'b0000001000,
    ST_POW   = 10'b0000010000,
    ST_AGE   = 10'b0000100000,
    ST_INC1  = 10'b0001000000,
    ST_INC2  = 10'b0010000000,
    ST_INC3  = 10'b0100000000,
    ST_WRITE = 10'b1000000000
  } state_t;

endpackage

// ----- src/delivery_predictability_table_unit.sv -----
// ----------------------------------------------------------------------------
// delivery_predictability_table_unit
// path: skipped results and out-of-table reads strobe from idle, reads pass READ,
// encounters pass READ, DIV, POW, AGE, INC1, WRITE, transitive ones add INC2, INC3;
// one aging step per bit of elapsed seconds; one transaction at a time, busy high
// until the result strobe, low throughout for results from idle; reset clears all
// NODE_COUNT entries with busy high meanwhile; results cannot be stalled
// ----------------------------------------------------------------------------
module delivery_predictability_table_unit
  import dpt_pkg::*;
#(
  parameter int NODE_COUNT = DPT_NODE_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_action,
  input  logic [ID_W-1:0]       in_node_id,
  input  logic [FIELD_W-1:0]    in_neighbor_prob,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_strobe,
  output logic [FIELD_W-1:0]    out_prob,
  output logic                  out_skipped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PROB_FRAC_BITS = DPT_FRAC_BITS;
  localparam int AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int PW  = PROB_FRAC_BITS + 1;
  localparam int MW  = 2 * PW;
  localparam logic [PW-1:0] ONE = PW'(1) << PROB_FRAC_BITS;
  localparam int ENTRY_W = 1 + PW + TIME_W;
  localparam int SEC_SHIFT = 38;
  localparam int QW = TIME_W + 32;
  localparam logic [31:0] SEC_RECIP =
    32'(((64'd1 << SEC_SHIFT) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));

  function automatic logic [PW-1:0] sat(input logic [FIELD_W-1:0] v);
    logic [FIELD_W:0] w;
    w = {1'b0, v};
    if (w > (FIELD_W+1)'(ONE)) return ONE;
    return PW'(v);
  endfunction

  function automatic logic [PW-1:0] qmul(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [MW-1:0] m;
    m = MW'(a) * MW'(b);
    return PW'(m >> PROB_FRAC_BITS);
  endfunction

  logic [ENTRY_W-1:0] mem [NODE_COUNT];
  logic [ENTRY_W-1:0] rd_r;

  state_t state_r;
  logic [AW-1:0]  clr_r;
  logic [ID_W-1:0] self_r, nb_r;
  logic [PW-1:0]  gamma_r, beta_r, pinit_r, enc_r;
  logic [1:0]     act_r;
  logic [AW-1:0]  addr_r;
  logic [PW-1:0]  nprob_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] quo_r;
  logic [PW-1:0]  acc_r, base_r, p_r, inc_r;

  logic [FIELD_W-1:0] out_prob_r;
  logic out_strobe_r, out_skipped_r;

  logic accept, cfg_wr, in_table;
  logic [ID_W-1:0] cfg_id;
  logic [AW-1:0] rd_addr;
  logic [QW-1:0] quo_prod;
  logic [PW-1:0] p_sum;
  logic [PW:0] p_add;

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE) && !start;
  assign accept     = start && !busy;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign cfg_id     = cfg_data[ID_W-1:0];
  assign in_table   = (32'(in_node_id) < 32'(NODE_COUNT));
  assign out_strobe = out_strobe_r;
  assign out_prob   = out_prob_r;
  assign out_skipped = out_skipped_r;

  assign rd_addr  = (state_r == ST_IDLE) ? AW'(in_node_id) : addr_r;
  assign quo_prod = QW'(quo_r) * QW'(SEC_RECIP);
  assign p_add  = {1'b0, p_r} + {1'b0, inc_r};
  assign p_sum  = (p_add > (PW+1)'(ONE)) ? ONE : PW'(p_add);

  // memory port
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_r] <= (32'(clr_r) == 32'(self_r)) ? {1'b1, ONE, TIME_W'(0)} : '0;
    end else if (cfg_wr && cfg_index == REG_SELF_ID && 32'(cfg_id) < 32'(NODE_COUNT)) begin
      mem[AW'(cfg_id)] <= {1'b1, ONE, TIME_W'(0)};
    end else if (state_r == ST_WRITE) begin
      mem[addr_r] <= {1'b1, p_sum, now_r};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      self_r <= '0;
      nb_r <= '0;
      enc_r <= '0;
      gamma_r <= PW'(GAMMA_RESET);
      beta_r <= PW'(BETA_RESET);
      pinit_r <= PW'(P_INIT_RESET);
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_wr) begin
        case (cfg_index)
          REG_SELF_ID: self_r <= cfg_id;
          REG_GAMMA: gamma_r <= sat(cfg_data[FIELD_W-1:0]);
          REG_BETA: beta_r <= sat(cfg_data[FIELD_W-1:0]);
          REG_P_INIT: pinit_r <= sat(cfg_data[FIELD_W-1:0]);
          default: ;
        endcase
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == NODE_COUNT - 1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            act_r <= in_action;
            addr_r <= AW'(in_node_id);
            nprob_r <= sat(in_neighbor_prob);
            now_r <= in_now_ms;
            if (in_action == ACT_READ) begin
              if (in_table) begin
                state_r <= ST_READ;
              end else begin
                out_strobe_r <= 1'b1;
                out_prob_r <= '0;
                out_skipped_r <= 1'b0;
              end
            end else if (!in_table || in_node_id == self_r ||
                         (in_action == ACT_TRANSITIVE && in_node_id == nb_r) ||
                         in_action == ACT_NONE) begin
              out_strobe_r <= 1'b1;
              out_prob_r <= '0;
              out_skipped_r <= 1'b1;
            end else begin
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (act_r == ACT_READ) begin
            out_strobe_r <= 1'b1;
            out_prob_r <= rd_r[ENTRY_W-1] ? FIELD_W'(rd_r[TIME_W +: PW]) : '0;
            out_skipped_r <= 1'b0;
            state_r <= ST_IDLE;
          end else begin
            quo_r <= now_r - rd_r[TIME_W-1:0];
            p_r <= rd_r[ENTRY_W-1] ? rd_r[TIME_W +: PW] : '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // whole seconds by reciprocal multiply, exact for 32-bit operands
          quo_r <= TIME_W'(quo_prod >> SEC_SHIFT);
          state_r <= ST_POW;
          acc_r <= ONE;
          base_r <= gamma_r;
        end
        ST_POW: begin
          if (quo_r == '0) begin
            state_r <= ST_AGE;
          end else begin
            if (quo_r[0]) acc_r <= qmul(acc_r, base_r);
            base_r <= qmul(base_r, base_r);
            quo_r <= quo_r >> 1;
          end
        end
        ST_AGE: begin
          p_r <= qmul(p_r, acc_r);
          state_r <= ST_INC1;
        end
        ST_INC1: begin
          inc_r <= qmul(ONE - p_r, (act_r == ACT_ENCOUNTER) ? pinit_r : enc_r);
          state_r <= (act_r == ACT_ENCOUNTER) ? ST_WRITE : ST_INC2;
        end
        ST_INC2: begin
          inc_r <= qmul(inc_r, nprob_r);
          state_r <= ST_INC3;
        end
        ST_INC3: begin
          inc_r <= qmul(inc_r, beta_r);
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          if (act_r == ACT_ENCOUNTER) begin
            nb_r <= ID_W'(addr_r);
            enc_r <= p_sum;
          end
          out_strobe_r <= 1'b1;
          out_prob_r <= FIELD_W'(p_sum);
          out_skipped_r <= 1'b0;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/dpt_checker.sv -----
// ----------------------------------------------------------------------------
// dpt_checker
// port-level checks for the delivery predictability table
// ----------------------------------------------------------------------------
module dpt_checker
  import dpt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic [FIELD_W-1:0] out_prob,
  input logic               out_skipped
);

  // reset must leave busy high; an accepted transaction holds busy off only for immediate results
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && busy |=> !out_strobe)
    else $error("double strobe");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_skipped |-> out_prob == '0)
    else $error("skipped result nonzero");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_prob <= FIELD_W'(65536))
    else $error("prob above one");

endmodule

bind delivery_predictability_table_unit dpt_checker u_dpt_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_prob(out_prob), .out_skipped(out_skipped)
);
